/* hw/rtl/lft_pkg.sv */
package lft_pkg;

   localparam int CountWidth = 16;
   localparam int FloorWidth = 16;
   localparam int StateWidth = 3;
   localparam int DirWidth   = 2;
   localparam int OpWidth    = 2;
   localparam int CsrIdxWidth = 3;

   // Opcodes
   localparam logic [OpWidth-1:0] OP_TICK   = 2'd0;
   localparam logic [OpWidth-1:0] OP_EDGE   = 2'd1;
   localparam logic [OpWidth-1:0] OP_PRESET = 2'd2;

   // Reported lift state
   localparam logic [StateWidth-1:0] ST_UNKNOWN   = 3'd0;
   localparam logic [StateWidth-1:0] ST_UP        = 3'd1;
   localparam logic [StateWidth-1:0] ST_DOWN      = 3'd2;
   localparam logic [StateWidth-1:0] ST_PAUSE     = 3'd3;
   localparam logic [StateWidth-1:0] ST_EXCEPTION = 3'd4;

   // Last move direction
   localparam logic [DirWidth-1:0] DIR_NONE = 2'd0;
   localparam logic [DirWidth-1:0] DIR_UP   = 2'd1;
   localparam logic [DirWidth-1:0] DIR_DOWN = 2'd2;

   // Configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_PAUSE_TICKS     = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_LONE_EDGE_TICKS = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_SILENCE_TICKS   = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_FAST_WINDOW     = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_TICK_WRAP       = 3'd4;

   // Configuration reset values
   localparam logic [CountWidth-1:0] PAUSE_TICKS_RST     = 16'd30;
   localparam logic [CountWidth-1:0] LONE_EDGE_TICKS_RST = 16'd10;
   localparam logic [CountWidth-1:0] SILENCE_TICKS_RST   = 16'd60;
   localparam logic [CountWidth-1:0] FAST_WINDOW_RST     = 16'd12;
   localparam logic [CountWidth-1:0] TICK_WRAP_RST       = 16'd65500;

   typedef struct packed {
      logic [CountWidth-1:0] pause_ticks;
      logic [CountWidth-1:0] lone_edge_ticks;
      logic [CountWidth-1:0] silence_ticks;
      logic [CountWidth-1:0] fast_window;
      logic [CountWidth-1:0] tick_wrap;
   } cfg_type;

   typedef struct packed {
      logic [OpWidth-1:0]           op;
      logic                         level_a;
      logic                         level_b;
      logic                         edge_a;
      logic                         edge_b;
      logic signed [FloorWidth-1:0] preset_floor;
   } req_item_type;

   typedef struct packed {
      logic signed [FloorWidth-1:0] floor;
      logic [StateWidth-1:0]        lift_state;
   } rsp_item_type;

endpackage

/* hw/rtl/lft_core.sv */
module lft_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  lft_pkg::cfg_type     cfg,
   input  lft_pkg::req_item_type item,
   output lft_pkg::rsp_item_type result
);
   import lft_pkg::*;

   function automatic logic [CountWidth-1:0] inc_sat(input logic [CountWidth-1:0] v);
      return (v == {CountWidth{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic logic signed [FloorWidth-1:0] sat_floor(
      input logic signed [FloorWidth:0] v);
      logic signed [FloorWidth:0] hi;
      logic signed [FloorWidth:0] lo;
      hi = {2'b00, {(FloorWidth-1){1'b1}}};
      lo = {2'b11, {(FloorWidth-1){1'b0}}};
      if (v > hi) return hi[FloorWidth-1:0];
      if (v < lo) return lo[FloorWidth-1:0];
      return v[FloorWidth-1:0];
   endfunction

   logic                         armed_ff, armed_in;
   logic [CountWidth-1:0]        lone_ff, lone_in;
   logic [CountWidth-1:0]        move_ff, move_in;
   logic [CountWidth-1:0]        run_a_ff, run_a_in;
   logic [CountWidth-1:0]        run_b_ff, run_b_in;
   logic                         prev_a_ff, prev_a_in;
   logic                         prev_b_ff, prev_b_in;
   logic [CountWidth-1:0]        tick_ff, tick_in;
   logic [CountWidth-1:0]        mark_ff, mark_in;
   logic [DirWidth-1:0]          dir_ff, dir_in;
   logic [StateWidth-1:0]        state_ff, state_in;
   logic signed [FloorWidth-1:0] floor_ff, floor_in;

   always_comb begin
      logic [CountWidth:0]        tick_next;
      logic signed [FloorWidth:0] f;
      logic [CountWidth-1:0]      span;
      armed_in  = armed_ff;
      lone_in   = lone_ff;
      move_in   = move_ff;
      run_a_in  = run_a_ff;
      run_b_in  = run_b_ff;
      prev_a_in = prev_a_ff;
      prev_b_in = prev_b_ff;
      tick_in   = tick_ff;
      mark_in   = mark_ff;
      dir_in    = dir_ff;
      state_in  = state_ff;
      floor_in  = floor_ff;
      tick_next = {1'b0, tick_ff} + 1'b1;
      f         = '0;
      span      = '0;
      case (item.op)
         OP_TICK: begin
            if (tick_next > {1'b0, cfg.tick_wrap}) begin
               tick_in = '0;
               mark_in = '0;
            end else begin
               tick_in = tick_next[CountWidth-1:0];
            end
            move_in   = inc_sat(move_ff);
            run_a_in  = (item.level_a && prev_a_ff) ? inc_sat(run_a_ff) : '0;
            run_b_in  = (item.level_b && prev_b_ff) ? inc_sat(run_b_ff) : '0;
            prev_a_in = item.level_a;
            prev_b_in = item.level_b;
            if (run_a_in > cfg.pause_ticks && run_b_in > cfg.pause_ticks) begin
               armed_in = 1'b0;
               run_a_in = '0;
               run_b_in = '0;
               lone_in  = '0;
               move_in  = '0;
               state_in = ST_PAUSE;
            end else if (armed_ff) begin
               lone_in = inc_sat(lone_ff);
               if (lone_in > cfg.lone_edge_ticks) begin
                  armed_in = 1'b0;
                  lone_in  = '0;
                  move_in  = '0;
                  state_in = ST_EXCEPTION;
               end
            end else if (move_in > cfg.silence_ticks) begin
               move_in  = '0;
               armed_in = 1'b0;
               state_in = ST_EXCEPTION;
            end
         end
         OP_EDGE: begin
            // A is handled first; B then sees what A left
            if (item.edge_a) begin
               if (!armed_in) begin
                  armed_in = 1'b1;
               end else begin
                  armed_in = 1'b0;
                  run_a_in = '0;
                  run_b_in = '0;
                  lone_in  = '0;
                  move_in  = '0;
                  f = {floor_in[FloorWidth-1], floor_in} - 17'sd1;
                  if (f == '0) f = '1;
                  floor_in = sat_floor(f);
                  state_in = ST_DOWN;
                  dir_in   = DIR_DOWN;
                  mark_in  = tick_ff;
               end
            end
            if (item.edge_b) begin
               if (!armed_in) begin
                  armed_in = 1'b1;
               end else begin
                  armed_in = 1'b0;
                  run_a_in = '0;
                  run_b_in = '0;
                  lone_in  = '0;
                  move_in  = '0;
                  f    = {floor_in[FloorWidth-1], floor_in} + 17'sd1;
                  span = tick_ff - mark_in;
                  mark_in = tick_ff;
                  if (span <= cfg.fast_window && dir_in == DIR_DOWN) begin
                     // fast repeat after a down move: net minus one
                     f = f - 17'sd2;
                  end else begin
                     if (f == '0) f = 17'sd1;
                     state_in = ST_UP;
                     dir_in   = DIR_UP;
                  end
                  floor_in = sat_floor(f);
               end
            end
         end
         OP_PRESET: begin
            floor_in = item.preset_floor;
            armed_in = 1'b0;
            run_a_in = '0;
            run_b_in = '0;
            lone_in  = '0;
            move_in  = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff  <= 1'b0;
         lone_ff   <= '0;
         move_ff   <= '0;
         run_a_ff  <= '0;
         run_b_ff  <= '0;
         prev_a_ff <= 1'b0;
         prev_b_ff <= 1'b0;
         tick_ff   <= '0;
         mark_ff   <= '0;
         dir_ff    <= DIR_NONE;
         state_ff  <= ST_UNKNOWN;
         floor_ff  <= '0;
      end else if (fire) begin
         armed_ff  <= armed_in;
         lone_ff   <= lone_in;
         move_ff   <= move_in;
         run_a_ff  <= run_a_in;
         run_b_ff  <= run_b_in;
         prev_a_ff <= prev_a_in;
         prev_b_ff <= prev_b_in;
         tick_ff   <= tick_in;
         mark_ff   <= mark_in;
         dir_ff    <= dir_in;
         state_ff  <= state_in;
         floor_ff  <= floor_in;
      end
   end

   assign result.floor      = floor_in;
   assign result.lift_state = state_in;

endmodule

/* hw/rtl/lift_direction_floor_tracker_unit.sv */
// Lift direction and floor tracker.
// An accepted req beat passes through the input register, then the state update
// lands in the result register; the state update is combinational.
// Throughput: 1 beat per cycle while rsp_tready stays high.
// Reset: synchronous, active high; clears tracking state and loads the
// default thresholds; no clearing pass.
module lift_direction_floor_tracker_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [0] level_a, [1] level_b, [2] edge_a, [3] edge_b, [19:4] preset_floor,
   // [23:20] zero
   input  logic [23:0]                       req_tdata,
   // [1:0] op
   input  logic [lft_pkg::OpWidth-1:0]       req_tuser,
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [15:0] floor, [18:16] lift_state, [23:19] zero
   output logic [23:0]                       rsp_tdata,
   // register write port
   input  logic                              csr_we,
   input  logic [lft_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [lft_pkg::CountWidth-1:0]    csr_wdata
);
   import lft_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   rsp_item_type core_result;
   logic         advance;

   // Register writes; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PAUSE_TICKS:     cfg_in.pause_ticks     = csr_wdata;
            CSR_LONE_EDGE_TICKS: cfg_in.lone_edge_ticks = csr_wdata;
            CSR_SILENCE_TICKS:   cfg_in.silence_ticks   = csr_wdata;
            CSR_FAST_WINDOW:     cfg_in.fast_window     = csr_wdata;
            CSR_TICK_WRAP:       cfg_in.tick_wrap       = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // The held beat moves into the result register whenever that register
   // is empty or being drained this cycle; the input register refills in
   // the same cycle, so beats stream back to back.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_item_in.op           = req_tuser;
         in_item_in.level_a      = req_tdata[0];
         in_item_in.level_b      = req_tdata[1];
         in_item_in.edge_a       = req_tdata[2];
         in_item_in.edge_b       = req_tdata[3];
         in_item_in.preset_floor = req_tdata[19:4];
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_item_in  = core_result;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pause_ticks     <= PAUSE_TICKS_RST;
         cfg_ff.lone_edge_ticks <= LONE_EDGE_TICKS_RST;
         cfg_ff.silence_ticks   <= SILENCE_TICKS_RST;
         cfg_ff.fast_window     <= FAST_WINDOW_RST;
         cfg_ff.tick_wrap       <= TICK_WRAP_RST;
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: no reset needed
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   // Tracking state and the per-beat update
   lft_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .cfg    (cfg_ff),
      .item   (in_item_ff),
      .result (core_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_item_ff.lift_state, out_item_ff.floor};

endmodule
